[hw/rtl/sha1h_pkg.sv]
// SHA-1 hasher package: transaction types, round constants and chaining initial values.
// Used by sha1_hasher_top; depends on nothing else.

package sha1h_pkg;

    // Input transaction: one message byte and its flags
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in_item;

    // Output transaction: one digest word
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    localparam int unsigned NUM_ROUNDS   = 80;
    localparam int unsigned DIGEST_WORDS = 5;

    // Round constants, one per group of twenty rounds
    localparam logic [31:0] K_R0 = 32'h5a827999;
    localparam logic [31:0] K_R1 = 32'h6ed9eba1;
    localparam logic [31:0] K_R2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_R3 = 32'hca62c1d6;

    // Chaining value after initialisation
    localparam logic [31:0] H_INIT0 = 32'h67452301;
    localparam logic [31:0] H_INIT1 = 32'hefcdab89;
    localparam logic [31:0] H_INIT2 = 32'h98badcfe;
    localparam logic [31:0] H_INIT3 = 32'h10325476;
    localparam logic [31:0] H_INIT4 = 32'hc3d2e1f0;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] h_init(input logic [2:0] idx);
        logic [31:0] val;
        case (idx)
            3'd0:    val = H_INIT0;
            3'd1:    val = H_INIT1;
            3'd2:    val = H_INIT2;
            3'd3:    val = H_INIT3;
            default: val = H_INIT4;
        endcase
        return val;
    endfunction

endpackage

[hw/rtl/sha1_hasher_top.sv]
// SHA-1 hasher top level: byte intake, block buffer memory, chaining value memory,
// 80-round compression sequencer and digest output register. Depends on sha1h_pkg.

// The block takes one byte transaction per cycle while it is idle. Every 64th byte,
// and every end-of-message transaction, starts a compression: a read of the chaining
// value out of its five-word memory, 80 rounds fed from the 16-word block buffer
// memory and a 16-word schedule shift line, and an addition of the working variables
// back into the chaining value memory. Input is stalled throughout a compression.
// The end of a message adds one compression, or two when fewer than nine bytes of
// the last block are free, followed by five digest words, each loaded once the output
// register is empty. The last digest word may still wait in the output register
// while the first bytes of the next message are taken. No clearing pass is needed
// after reset.

module sha1_hasher_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  sha1h_pkg::t_in_item   i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output sha1h_pkg::t_out_item  o_data
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOADH = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_WBACK = 3'd3;
    localparam logic [2:0] ST_OUTRD = 3'd4;
    localparam logic [2:0] ST_OUTLD = 3'd5;

    // Kind of block being compressed
    localparam logic [1:0] BLK_DATA = 2'd0;
    localparam logic [1:0] BLK_PAD  = 2'd1;
    localparam logic [1:0] BLK_LEN  = 2'd2;

    localparam logic [6:0] LAST_ROUND = 7'(sha1h_pkg::NUM_ROUNDS - 1);
    localparam logic [6:0] H_STEPS    = 7'(sha1h_pkg::DIGEST_WORDS);
    localparam logic [6:0] LAST_WORD  = 7'(sha1h_pkg::DIGEST_WORDS - 1);
    localparam logic [2:0] LAST_IDX   = 3'(sha1h_pkg::DIGEST_WORDS - 1);

    // Memories
    logic [31:0] m_chain [0:4];
    logic [31:0] m_buf   [0:15];

    // Control registers
    logic [2:0]  r_state, n_state;
    logic [6:0]  r_cnt,   n_cnt;
    logic [1:0]  r_mode,  n_mode;
    logic        r_fin,   n_fin;
    logic [5:0]  r_fill,  n_fill;
    logic [63:0] r_len,   n_len;
    logic [4:0]  r_hval,  n_hval;
    logic        r_ovalid, n_ovalid;

    // Payload registers
    logic [31:0] r_word, n_word;
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] n_a, n_b, n_c, n_d, n_e;
    logic [31:0] r_w [0:15];
    logic [31:0] n_w [0:15];
    sha1h_pkg::t_out_item r_out, n_out;

    // Memory read registers
    logic [31:0] r_hrd;
    logic        r_hrd_val;
    logic [2:0]  r_hidx;
    logic [31:0] r_brd;

    // Combinational helpers
    logic        in_acc;
    logic [31:0] byte_word;
    logic        buf_we;
    logic [3:0]  buf_raddr;
    logic        h_re;
    logic [2:0]  h_raddr;
    logic        h_we;
    logic [31:0] h_data;
    logic [31:0] var_sel;
    logic [3:0]  wj;
    logic [3:0]  fw;
    logic        with_len;
    logic [31:0] pad_word;
    logic [31:0] len_word;
    logic [31:0] w_src;
    logic [31:0] w_cur;
    logic [31:0] w_mix;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_val;

    assign in_acc    = i_valid && (r_state == ST_IDLE);
    assign o_stall   = (r_state != ST_IDLE);
    assign o_valid   = r_ovalid;
    assign o_data    = r_out;
    assign byte_word = {r_word[23:0], i_data.msg_byte};

    // Buffer memory: write a completed word, read one word ahead of the rounds
    assign buf_we    = in_acc && i_data.byte_valid && (r_fill[1:0] == 2'd3);
    assign buf_raddr = (r_state == ST_ROUND) ? (r_cnt[3:0] + 4'd1) : 4'd0;

    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            m_buf[r_fill[5:2]] <= byte_word;
        end
        r_brd <= m_buf[buf_raddr];
    end

    // Chaining memory: sequential reads for load, write-back and digest output
    assign h_raddr = r_cnt[2:0];
    assign h_re    = (r_cnt < H_STEPS) &&
                     ((r_state == ST_LOADH) || (r_state == ST_WBACK) ||
                      ((r_state == ST_OUTRD) && !r_ovalid));
    assign h_we    = (r_state == ST_WBACK) && (r_cnt != 7'd0);
    assign h_data  = r_hrd_val ? r_hrd : sha1h_pkg::h_init(r_hidx);

    always_comb begin
        case (r_hidx)
            3'd0:    var_sel = r_a;
            3'd1:    var_sel = r_b;
            3'd2:    var_sel = r_c;
            3'd3:    var_sel = r_d;
            default: var_sel = r_e;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (h_re) begin
            r_hrd     <= m_chain[h_raddr];
            r_hrd_val <= r_hval[h_raddr];
            r_hidx    <= h_raddr;
        end
        if (h_we) begin
            m_chain[r_hidx] <= h_data + var_sel;
        end
    end

    // Message schedule word for the current round, padding made on the fly
    assign wj       = r_cnt[3:0];
    assign fw       = r_fill[5:2];
    assign with_len = (r_fill < 6'd56);
    assign len_word = (wj == 4'd14) ? r_len[63:32] :
                      (wj == 4'd15) ? r_len[31:0]  : 32'd0;

    always_comb begin
        case (r_fill[1:0])
            2'd0:    pad_word = {sha1h_pkg::PAD_BYTE, 24'd0};
            2'd1:    pad_word = {r_word[7:0],  sha1h_pkg::PAD_BYTE, 16'd0};
            2'd2:    pad_word = {r_word[15:0], sha1h_pkg::PAD_BYTE, 8'd0};
            default: pad_word = {r_word[23:0], sha1h_pkg::PAD_BYTE};
        endcase
    end

    always_comb begin
        case (r_mode)
            BLK_DATA: w_src = r_brd;
            BLK_PAD: begin
                if (wj < fw) begin
                    w_src = r_brd;
                end else if (wj == fw) begin
                    w_src = pad_word;
                end else begin
                    w_src = with_len ? len_word : 32'd0;
                end
            end
            BLK_LEN:  w_src = len_word;
            default:  w_src = r_brd;
        endcase
    end

    assign w_mix = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_cur = (r_cnt < 7'd16) ? w_src : {w_mix[30:0], w_mix[31]};

    // Round function and constant by group of twenty rounds
    always_comb begin
        if (r_cnt < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = sha1h_pkg::K_R0;
        end else if (r_cnt < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = sha1h_pkg::K_R1;
        end else if (r_cnt < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = sha1h_pkg::K_R2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = sha1h_pkg::K_R3;
        end
    end

    assign t_val = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + w_cur;

    // Sequencer and next-state logic
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_mode   = r_mode;
        n_fin    = r_fin;
        n_fill   = r_fill;
        n_len    = r_len;
        n_hval   = r_hval;
        n_ovalid = r_ovalid;
        n_word   = r_word;
        n_a      = r_a;
        n_b      = r_b;
        n_c      = r_c;
        n_d      = r_d;
        n_e      = r_e;
        n_out    = r_out;
        for (int i = 0; i < 16; i++) begin
            n_w[i] = r_w[i];
        end

        // Drop the output transaction once taken
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_data.byte_valid) begin
                        n_word = byte_word;
                        n_fill = r_fill + 6'd1;
                        n_len  = r_len + 64'd8;
                    end
                    if (i_data.byte_valid && (r_fill == 6'd63)) begin
                        n_state = ST_LOADH;
                        n_cnt   = 7'd0;
                        n_mode  = BLK_DATA;
                        n_fin   = i_data.end_of_message;
                    end else if (i_data.end_of_message) begin
                        n_state = ST_LOADH;
                        n_cnt   = 7'd0;
                        n_mode  = BLK_PAD;
                    end
                end
            end
            ST_LOADH: begin
                // Capture chaining words into the working variables
                if (r_cnt != 7'd0) begin
                    case (r_hidx)
                        3'd0:    n_a = h_data;
                        3'd1:    n_b = h_data;
                        3'd2:    n_c = h_data;
                        3'd3:    n_d = h_data;
                        default: n_e = h_data;
                    endcase
                end
                if (r_cnt == H_STEPS) begin
                    n_state = ST_ROUND;
                    n_cnt   = 7'd0;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            ST_ROUND: begin
                n_a = t_val;
                n_b = r_a;
                n_c = {r_b[1:0], r_b[31:2]};
                n_d = r_c;
                n_e = r_d;
                for (int i = 0; i < 15; i++) begin
                    n_w[i] = r_w[i + 1];
                end
                n_w[15] = w_cur;
                if (r_cnt == LAST_ROUND) begin
                    n_state = ST_WBACK;
                    n_cnt   = 7'd0;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            ST_WBACK: begin
                if (h_we) begin
                    n_hval[r_hidx] = 1'b1;
                end
                if (r_cnt == H_STEPS) begin
                    n_cnt = 7'd0;
                    case (r_mode)
                        BLK_DATA: begin
                            if (r_fin) begin
                                n_state = ST_LOADH;
                                n_mode  = BLK_PAD;
                                n_fin   = 1'b0;
                            end else begin
                                n_state = ST_IDLE;
                            end
                        end
                        BLK_PAD: begin
                            if (with_len) begin
                                n_state = ST_OUTRD;
                            end else begin
                                n_state = ST_LOADH;
                                n_mode  = BLK_LEN;
                            end
                        end
                        default: n_state = ST_OUTRD;
                    endcase
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            ST_OUTRD: begin
                // Wait for an empty output register, read issued once it is empty
                if (!r_ovalid) begin
                    n_state = ST_OUTLD;
                end
            end
            ST_OUTLD: begin
                n_out.digest_word = h_data;
                n_out.word_index  = r_hidx;
                n_out.last_word   = (r_hidx == LAST_IDX);
                n_ovalid          = 1'b1;
                if (r_cnt == LAST_WORD) begin
                    // Reinitialise for the next message
                    n_state = ST_IDLE;
                    n_cnt   = 7'd0;
                    n_fill  = 6'd0;
                    n_len   = 64'd0;
                    n_hval  = 5'd0;
                end else begin
                    n_state = ST_OUTRD;
                    n_cnt   = r_cnt + 7'd1;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = 7'd0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= 7'd0;
            r_mode   <= BLK_DATA;
            r_fin    <= 1'b0;
            r_fill   <= 6'd0;
            r_len    <= 64'd0;
            r_hval   <= 5'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_mode   <= n_mode;
            r_fin    <= n_fin;
            r_fill   <= n_fill;
            r_len    <= n_len;
            r_hval   <= n_hval;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_d    <= n_d;
        r_e    <= n_e;
        r_out  <= n_out;
        for (int i = 0; i < 16; i++) begin
            r_w[i] <= n_w[i];
        end
    end

    // Output register is only loaded when empty
    a_load_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUTLD) |-> !r_ovalid)
        else $error("digest word loaded over a pending transaction");

    // Round counter stays inside the eighty rounds
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_cnt <= LAST_ROUND))
        else $error("round counter out of range");

    // Last flag marks exactly the fifth word
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.last_word == (o_data.word_index == LAST_IDX)))
        else $error("last_word does not match word_index");

    // An end-of-message transaction always starts a compression
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_data.end_of_message) |=> o_stall)
        else $error("end of message did not start padding");

    // Chaining valid bits never change outside write-back and the digest word load
    a_valid_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_WBACK && r_state != ST_OUTLD) |=> (r_hval == $past(r_hval)))
        else $error("chaining valid bits changed outside write-back");

endmodule
